/* rtl/fcd_pkg.sv */
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types and constants of the FAST corner detection core: window
// geometry, circle taps, register map and reset values.
// ----------------------------------------------------------------------------
package fcd_pkg;

  // Neighbourhood geometry
  localparam int unsigned WIN      = 7;
  localparam int unsigned LINES    = 6;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned LINE_W   = LINES * PIX_W;
  localparam int unsigned CIRC_N   = 16;
  localparam int unsigned CENTRE   = 3;
  localparam int unsigned COORD_W  = 10;

  // Frame geometry limits
  localparam int unsigned DIM_W    = 11;
  localparam int unsigned DIM_MIN  = 7;
  localparam int unsigned HEIGHT_MAX = 1024;
  localparam int unsigned BORDER   = 6;

  // Configuration register map
  typedef enum logic [1:0] {
    REG_THRESHOLD    = 2'd0,
    REG_ARC_LENGTH   = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } cfg_reg_e;

  localparam logic [7:0]       THRESHOLD_RST    = 8'd9;
  localparam logic [4:0]       ARC_LENGTH_RST   = 5'd12;
  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

  // Circle taps, clockwise from the top, as window row / column indexes
  localparam logic [2:0] CIRC_ROW [CIRC_N] = '{
    3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
    3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
  };
  localparam logic [2:0] CIRC_COL [CIRC_N] = '{
    3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4,
    3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2
  };

  // 7x7 pixel window, [row][column], column WIN-1 is the newest
  typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] window_t;

  // Segment test verdict
  typedef struct packed {
    logic is_corner;
    logic is_brighter;
  } seg_result_t;

endpackage

/* rtl/fcd_line_store.sv */
// ----------------------------------------------------------------------------
// fcd_line_store
// Six line buffers held as one memory of 48-bit words, one word per column.
// One read and one write per cycle; a read that meets a write to the same
// column in the same cycle returns the word being written.
// ----------------------------------------------------------------------------
module fcd_line_store #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]         rd_addr_i,
  input  logic                                 wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]         wr_addr_i,
  input  logic [fcd_pkg::LINE_W-1:0]           wr_data_i,
  output logic [fcd_pkg::LINE_W-1:0]           rd_data_o
);

  logic [fcd_pkg::LINE_W-1:0] mem [MAX_WIDTH];
  logic [fcd_pkg::LINE_W-1:0] mem_rdata_q;
  logic [fcd_pkg::LINE_W-1:0] byp_data_q;
  logic                       byp_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      mem_rdata_q <= mem[rd_addr_i];
      byp_data_q  <= wr_data_i;
    end
  end

  // Remember a same-column collision so the fresh word wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : mem_rdata_q;

endmodule

/* rtl/fcd_segment_test.sv */
// ----------------------------------------------------------------------------
// fcd_segment_test
// Segment test on the 16-pixel circle of a 7x7 window: builds the brighter
// and darker masks and looks for a wrapping arc of the requested length.
// ----------------------------------------------------------------------------
module fcd_segment_test (
  input  fcd_pkg::window_t     window_i,
  input  logic [7:0]           threshold_i,
  input  logic [4:0]           arc_length_i,
  output fcd_pkg::seg_result_t result_o
);

  logic [8:0]                  centre;
  logic [8:0]                  thr;
  logic [8:0]                  pix;
  logic [fcd_pkg::CIRC_N-1:0]  bright_mask;
  logic [fcd_pkg::CIRC_N-1:0]  dark_mask;
  logic [fcd_pkg::CIRC_N-1:0]  len_mask;
  logic [fcd_pkg::CIRC_N-1:0]  req;
  logic [2*fcd_pkg::CIRC_N-1:0] rot;
  logic [fcd_pkg::CIRC_N-1:0]  bright_hit;
  logic [fcd_pkg::CIRC_N-1:0]  dark_hit;
  logic [fcd_pkg::CIRC_N-1:0]  any_hit;
  logic [fcd_pkg::CIRC_N-1:0]  first_hit;

  // Compare each circle pixel against the centre, strict on both sides
  always_comb begin
    centre = {1'b0, window_i[fcd_pkg::CENTRE][fcd_pkg::CENTRE]};
    thr    = {1'b0, threshold_i};
    pix    = '0;
    for (int i = 0; i < fcd_pkg::CIRC_N; i++) begin
      pix            = {1'b0, window_i[fcd_pkg::CIRC_ROW[i]][fcd_pkg::CIRC_COL[i]]};
      bright_mask[i] = pix > (centre + thr);
      dark_mask[i]   = (pix + thr) < centre;
    end
  end

  // Test an arc at every start position; lengths of 16 and up need the full ring
  always_comb begin
    len_mask = arc_length_i[4] ? '1 : ~({fcd_pkg::CIRC_N{1'b1}} << arc_length_i[3:0]);
    rot      = '0;
    req      = '0;
    for (int i = 0; i < fcd_pkg::CIRC_N; i++) begin
      rot           = {len_mask, len_mask} << i;
      req           = rot[2*fcd_pkg::CIRC_N-1:fcd_pkg::CIRC_N];
      bright_hit[i] = (bright_mask & req) == req;
      dark_hit[i]   = (dark_mask & req) == req;
    end
  end

  // Lowest start wins, brighter before darker at the same start
  assign any_hit   = bright_hit | dark_hit;
  assign first_hit = any_hit & (~any_hit + fcd_pkg::CIRC_N'(1));

  assign result_o.is_corner   = |any_hit;
  assign result_o.is_brighter = |(first_hit & bright_hit);

endmodule

/* rtl/fast_corner_detection_core.sv */
// ----------------------------------------------------------------------------
// fast_corner_detection_core
// FAST-16 segment-test corner detector over a raster stream of grey pixels.
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock in raster order and gives one word per
// centre that lies at least three pixels inside every border: its column,
// its row, a corner flag and a brighter/darker flag. Pixels near the border
// give no word. The throughput is one pixel per clock while the output is
// not stalled, set by the single read port and single write port of the
// line store; each result passes through the line store read, the window
// shift and the segment test into the output register. The six previous
// lines live in one memory of MAX_WIDTH words of 48 bits; it is not cleared
// after reset and the first six rows of a frame fill it. Configuration writes
// take effect at once and are meant for idle periods between frames.
// ----------------------------------------------------------------------------
module fast_corner_detection_core #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_value
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [9:0] centre_x, [19:10] centre_y,
                                      // [20] is_corner, [21] is_brighter, zero fill
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_wdata_i
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (XW + 1 > fcd_pkg::DIM_W) ? XW + 1 : fcd_pkg::DIM_W;
  localparam int unsigned XE = (XW > fcd_pkg::COORD_W) ? XW : fcd_pkg::COORD_W;
  localparam int unsigned CW = fcd_pkg::COORD_W;

  // Configuration registers
  logic [7:0]                threshold_q;
  logic [4:0]                arc_length_q;
  logic [fcd_pkg::DIM_W-1:0] width_q;
  logic [fcd_pkg::DIM_W-1:0] height_q;

  // Raster position
  logic [XW-1:0]             col_q, col_d;
  logic [CW-1:0]             row_q, row_d;
  logic [XW-1:0]             x_cur;
  logic [CW-1:0]             y_cur;
  logic [WW-1:0]             w_ext, w_sat, x_ext;
  logic [fcd_pkg::DIM_W-1:0] h_sat, y_ext;
  logic [XE-1:0]             x_wide;
  logic                      in_frame;

  // Handshake and stage control
  logic accept;
  logic out_free, s2_free, s1_adv, s1_free;

  // Stage 1: pixel waiting for its line store column
  logic                      s1_vq;
  logic [7:0]                s1_pix_q;
  logic [XW-1:0]             s1_addr_q;
  logic                      s1_hit_q;
  logic [CW-1:0]             s1_cx_q, s1_cy_q;
  logic [fcd_pkg::LINE_W-1:0] rd_word;
  logic [fcd_pkg::LINE_W-1:0] wr_word;

  // Stage 2: window ready for the segment test
  fcd_pkg::window_t          win_q;
  logic                      s2_vq;
  logic [CW-1:0]             s2_cx_q, s2_cy_q;
  fcd_pkg::seg_result_t      seg;

  // Output register
  logic                      out_vq;
  logic [23:0]               out_data_q;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= fcd_pkg::THRESHOLD_RST;
      arc_length_q <= fcd_pkg::ARC_LENGTH_RST;
      width_q      <= fcd_pkg::IMAGE_WIDTH_RST;
      height_q     <= fcd_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (fcd_pkg::cfg_reg_e'(cfg_index_i))
        fcd_pkg::REG_THRESHOLD:    threshold_q  <= cfg_wdata_i[7:0];
        fcd_pkg::REG_ARC_LENGTH:   arc_length_q <= cfg_wdata_i[4:0];
        fcd_pkg::REG_IMAGE_WIDTH:  width_q      <= cfg_wdata_i;
        fcd_pkg::REG_IMAGE_HEIGHT: height_q     <= cfg_wdata_i;
        default:                   ;
      endcase
    end
  end

  // Pipeline flow: each stage moves when the one after it has room
  assign out_free      = !out_vq || m_axis_tready;
  assign s2_free       = !s2_vq || out_free;
  assign s1_adv        = s1_vq && s2_free;
  assign s1_free       = !s1_vq || s1_adv;
  assign s_axis_tready = s1_free;
  assign accept        = s_axis_tvalid && s1_free;

  // Clamp the frame geometry and place the incoming pixel
  always_comb begin
    w_ext = WW'(width_q);
    if (w_ext < WW'(fcd_pkg::DIM_MIN)) begin
      w_sat = WW'(fcd_pkg::DIM_MIN);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = w_ext;
    end
    if (height_q < fcd_pkg::DIM_W'(fcd_pkg::DIM_MIN)) begin
      h_sat = fcd_pkg::DIM_W'(fcd_pkg::DIM_MIN);
    end else if (height_q > fcd_pkg::DIM_W'(fcd_pkg::HEIGHT_MAX)) begin
      h_sat = fcd_pkg::DIM_W'(fcd_pkg::HEIGHT_MAX);
    end else begin
      h_sat = height_q;
    end

    x_cur  = s_axis_tuser[0] ? '0 : col_q;
    y_cur  = s_axis_tuser[0] ? '0 : row_q;
    x_ext  = WW'(x_cur);
    y_ext  = fcd_pkg::DIM_W'(y_cur);
    x_wide = XE'(x_cur);

    in_frame = (x_ext >= WW'(fcd_pkg::BORDER)) && (y_ext >= fcd_pkg::DIM_W'(fcd_pkg::BORDER))
            && (x_ext < w_sat) && (y_ext < h_sat);

    // Advance the raster position, wrapping at row and frame end
    col_d = x_cur + XW'(1);
    row_d = y_cur;
    if ((x_ext + WW'(1)) >= w_sat) begin
      col_d = '0;
      row_d = y_cur + CW'(1);
      if ((y_ext + fcd_pkg::DIM_W'(1)) >= h_sat) begin
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vq <= 1'b0;
    end else if (s1_free) begin
      s1_vq <= accept;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= s_axis_tdata;
      s1_addr_q <= x_cur;
      s1_hit_q  <= in_frame;
      s1_cx_q   <= x_wide[CW-1:0] - CW'(fcd_pkg::CENTRE);
      s1_cy_q   <= y_cur - CW'(fcd_pkg::CENTRE);
    end
  end

  // Push the new pixel in at the bottom, drop the oldest line
  assign wr_word = {s1_pix_q, rd_word[fcd_pkg::LINE_W-1:fcd_pkg::PIX_W]};

  fcd_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (x_cur),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_word),
    .rd_data_o (rd_word)
  );

  // Shift the window left and load the new column on the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      for (int r = 0; r < fcd_pkg::WIN; r++) begin
        for (int c = 0; c < fcd_pkg::WIN - 1; c++) begin
          win_q[r][c] <= win_q[r][c+1];
        end
      end
      for (int r = 0; r < fcd_pkg::LINES; r++) begin
        win_q[r][fcd_pkg::WIN-1] <= rd_word[r*fcd_pkg::PIX_W +: fcd_pkg::PIX_W];
      end
      win_q[fcd_pkg::WIN-1][fcd_pkg::WIN-1] <= s1_pix_q;
    end
  end

  // Stage 2 control: valid only for centres that give a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vq <= 1'b0;
    end else if (s2_free) begin
      s2_vq <= s1_adv && s1_hit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_cx_q <= s1_cx_q;
      s2_cy_q <= s1_cy_q;
    end
  end

  fcd_segment_test u_segment_test (
    .window_i     (win_q),
    .threshold_i  (threshold_q),
    .arc_length_i (arc_length_q),
    .result_o     (seg)
  );

  // Output register: hold the word until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (out_free) begin
      out_vq <= s2_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s2_vq) begin
      out_data_q <= {2'b00, seg.is_brighter, seg.is_corner, s2_cy_q, s2_cx_q};
    end
  end

  assign m_axis_tvalid = out_vq;
  assign m_axis_tdata  = out_data_q;

endmodule
